FILE: rtl/cck_pkg.sv
// ----------------------------------------------------------------------------
// cck_pkg
// shared types, codes and the month length table for the calendar counter
// ----------------------------------------------------------------------------
package cck_pkg;

  localparam logic [6:0] YEAR_LAST = 7'd99;

  // operation codes of an input request
  localparam logic [2:0] OP_SEC_UP     = 3'd0;
  localparam logic [2:0] OP_SEC_DOWN   = 3'd1;
  localparam logic [2:0] OP_MIN_SHIFT  = 3'd2;
  localparam logic [2:0] OP_HOUR_SHIFT = 3'd3;
  localparam logic [2:0] OP_LOAD       = 3'd4;

  localparam logic [4:0] FEB_LEAP_DAYS = 5'd29;
  localparam logic [4:0] FEB_DAYS      = 5'd28;
  localparam logic [4:0] LONG_MONTH    = 5'd31;

  // february entry unused, handled by the leap rule
  localparam logic [4:0] MONTH_LEN [12] = '{
    5'd31, 5'd0, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_RUN
  } state_t;

  typedef enum logic [1:0] {
    UNIT_SEC,
    UNIT_MIN,
    UNIT_HOUR
  } unit_t;

  typedef struct packed {
    logic  load;
    logic  step;
    logic  capture;
    logic  up;
    unit_t unit;
  } dp_cmd_t;

  function automatic logic [4:0] days_of_month(input logic [3:0] month, input logic [6:0] year);
    logic [4:0] days;
    if (month == 4'd2) begin
      days = (year[1:0] == 2'd0) ? FEB_LEAP_DAYS : FEB_DAYS;
    end else if (month < 4'd1 || month > 4'd12) begin
      days = LONG_MONTH;
    end else begin
      days = MONTH_LEN[month - 4'd1];
    end
    return days;
  endfunction

endpackage

FILE: rtl/cck_ctrl.sv
// ----------------------------------------------------------------------------
// cck_ctrl
// request decode, step counter and output handshake control
// ----------------------------------------------------------------------------
module cck_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [2:0]        operation,
  input  logic [7:0]        delta,
  output logic              out_tvalid,
  input  logic              out_tready,
  output cck_pkg::dp_cmd_t  cmd
);

  cck_pkg::state_t state_r, state_nxt;
  cck_pkg::unit_t  unit_r, unit_nxt;
  logic            up_r, up_nxt;
  logic [7:0]      cnt_r, cnt_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            accept;
  logic            slot_free;
  logic [7:0]      shift_steps;

  assign in_tready  = (state_r == cck_pkg::ST_IDLE);
  assign accept     = in_tvalid & in_tready;
  assign slot_free  = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;

  // magnitude of the signed shift, 0x80 gives 128
  assign shift_steps = delta[7] ? (~delta + 8'd1) : delta;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cck_pkg::ST_IDLE;
      unit_r      <= cck_pkg::UNIT_SEC;
      up_r        <= 1'b1;
      cnt_r       <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      unit_r      <= unit_nxt;
      up_r        <= up_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    unit_nxt    = unit_r;
    up_nxt      = up_r;
    cnt_nxt     = cnt_r;
    cmd.load    = 1'b0;
    cmd.step    = 1'b0;
    cmd.capture = 1'b0;
    cmd.up      = up_r;
    cmd.unit    = unit_r;

    unique case (state_r)
      cck_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = cck_pkg::ST_RUN;
          cnt_nxt   = 8'd0;
          unique case (operation)
            cck_pkg::OP_SEC_UP: begin
              unit_nxt = cck_pkg::UNIT_SEC;
              up_nxt   = 1'b1;
              cnt_nxt  = 8'd1;
            end
            cck_pkg::OP_SEC_DOWN: begin
              unit_nxt = cck_pkg::UNIT_SEC;
              up_nxt   = 1'b0;
              cnt_nxt  = 8'd1;
            end
            cck_pkg::OP_MIN_SHIFT: begin
              unit_nxt = cck_pkg::UNIT_MIN;
              up_nxt   = !delta[7];
              cnt_nxt  = shift_steps;
            end
            cck_pkg::OP_HOUR_SHIFT: begin
              unit_nxt = cck_pkg::UNIT_HOUR;
              up_nxt   = !delta[7];
              cnt_nxt  = shift_steps;
            end
            cck_pkg::OP_LOAD: begin
              cmd.load = 1'b1;
            end
            default: begin
              cnt_nxt = 8'd0;
            end
          endcase
        end
      end
      cck_pkg::ST_RUN: begin
        if (cnt_r != 8'd0) begin
          cmd.step = 1'b1;
          cnt_nxt  = cnt_r - 8'd1;
        end else if (slot_free) begin
          cmd.capture = 1'b1;
          state_nxt   = cck_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = cck_pkg::ST_IDLE;
      end
    endcase

    if (cmd.capture) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

endmodule

FILE: rtl/cck_dp.sv
// ----------------------------------------------------------------------------
// cck_dp
// calendar registers, one unit step per cycle with ripple carry and borrow
// ----------------------------------------------------------------------------
module cck_dp (
  input  logic             clk,
  input  logic             rst_n,
  input  cck_pkg::dp_cmd_t cmd,
  input  logic [6:0]       load_year,
  input  logic [3:0]       load_month,
  input  logic [4:0]       load_day,
  input  logic [4:0]       load_hour,
  input  logic [5:0]       load_minute,
  input  logic [5:0]       load_second,
  output logic [6:0]       year_now,
  output logic [3:0]       month_now,
  output logic [4:0]       day_now,
  output logic [4:0]       hour_now,
  output logic [5:0]       minute_now,
  output logic [5:0]       second_now,
  output logic             fields_valid
);

  logic [6:0] year_r, year_nxt;
  logic [3:0] month_r, month_nxt;
  logic [4:0] day_r, day_nxt;
  logic [4:0] hour_r, hour_nxt;
  logic [5:0] minute_r, minute_nxt;
  logic [5:0] second_r, second_nxt;

  logic [6:0] year_o_r;
  logic [3:0] month_o_r;
  logic [4:0] day_o_r;
  logic [4:0] hour_o_r;
  logic [5:0] minute_o_r;
  logic [5:0] second_o_r;
  logic       valid_o_r;

  logic [4:0] dim_cur;
  logic       go_min, go_hour, go_day, go_mon, go_year;
  logic       valid_now;

  assign dim_cur = cck_pkg::days_of_month(month_r, year_r);

  assign valid_now = (year_r <= cck_pkg::YEAR_LAST) &&
                     (month_r >= 4'd1) && (month_r <= 4'd12) &&
                     (day_r >= 5'd1) && (day_r <= dim_cur) &&
                     (hour_r <= 5'd23) && (minute_r <= 6'd59) && (second_r <= 6'd59);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      year_r   <= 7'd0;
      month_r  <= 4'd1;
      day_r    <= 5'd1;
      hour_r   <= 5'd0;
      minute_r <= 6'd0;
      second_r <= 6'd0;
    end else begin
      year_r   <= year_nxt;
      month_r  <= month_nxt;
      day_r    <= day_nxt;
      hour_r   <= hour_nxt;
      minute_r <= minute_nxt;
      second_r <= second_nxt;
    end
  end

  // result snapshot
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      year_o_r   <= year_r;
      month_o_r  <= month_r;
      day_o_r    <= day_r;
      hour_o_r   <= hour_r;
      minute_o_r <= minute_r;
      second_o_r <= second_r;
      valid_o_r  <= valid_now;
    end
  end

  always_comb begin
    year_nxt   = year_r;
    month_nxt  = month_r;
    day_nxt    = day_r;
    hour_nxt   = hour_r;
    minute_nxt = minute_r;
    second_nxt = second_r;
    go_min     = (cmd.unit == cck_pkg::UNIT_MIN);
    go_hour    = (cmd.unit == cck_pkg::UNIT_HOUR);
    go_day     = 1'b0;
    go_mon     = 1'b0;
    go_year    = 1'b0;

    if (cmd.load) begin
      year_nxt   = load_year;
      month_nxt  = load_month;
      day_nxt    = load_day;
      hour_nxt   = load_hour;
      minute_nxt = load_minute;
      second_nxt = load_second;
    end else if (cmd.step && cmd.up) begin
      if (cmd.unit == cck_pkg::UNIT_SEC) begin
        if (second_r >= 6'd59) begin
          second_nxt = 6'd0;
          go_min     = 1'b1;
        end else begin
          second_nxt = second_r + 6'd1;
        end
      end
      if (go_min) begin
        if (minute_r >= 6'd59) begin
          minute_nxt = 6'd0;
          go_hour    = 1'b1;
        end else begin
          minute_nxt = minute_r + 6'd1;
        end
      end
      if (go_hour) begin
        if (hour_r >= 5'd23) begin
          hour_nxt = 5'd0;
          go_day   = 1'b1;
        end else begin
          hour_nxt = hour_r + 5'd1;
        end
      end
      // day limit is the length of the month before any carry
      if (go_day) begin
        if (day_r >= dim_cur) begin
          day_nxt = 5'd1;
          go_mon  = 1'b1;
        end else begin
          day_nxt = day_r + 5'd1;
        end
      end
      if (go_mon) begin
        if (month_r >= 4'd12) begin
          month_nxt = 4'd1;
          go_year   = 1'b1;
        end else begin
          month_nxt = month_r + 4'd1;
        end
      end
      if (go_year) begin
        year_nxt = (year_r >= cck_pkg::YEAR_LAST) ? 7'd0 : year_r + 7'd1;
      end
    end else if (cmd.step) begin
      if (cmd.unit == cck_pkg::UNIT_SEC) begin
        if (second_r > 6'd0) begin
          second_nxt = second_r - 6'd1;
        end else begin
          second_nxt = 6'd59;
          go_min     = 1'b1;
        end
      end
      if (go_min) begin
        if (minute_r > 6'd0) begin
          minute_nxt = minute_r - 6'd1;
        end else begin
          minute_nxt = 6'd59;
          go_hour    = 1'b1;
        end
      end
      if (go_hour) begin
        if (hour_r > 5'd0) begin
          hour_nxt = hour_r - 5'd1;
        end else begin
          hour_nxt = 5'd23;
          go_day   = 1'b1;
        end
      end
      if (go_day) begin
        if (day_r > 5'd1) begin
          day_nxt = day_r - 5'd1;
        end else begin
          if (month_r > 4'd1) begin
            month_nxt = month_r - 4'd1;
          end else begin
            month_nxt = 4'd12;
            year_nxt  = (year_r > 7'd0) ? year_r - 7'd1 : cck_pkg::YEAR_LAST;
          end
          // borrowed day lands on the last day of the new month
          day_nxt = cck_pkg::days_of_month(month_nxt, year_nxt);
        end
      end
    end
  end

  assign year_now     = year_o_r;
  assign month_now    = month_o_r;
  assign day_now      = day_o_r;
  assign hour_now     = hour_o_r;
  assign minute_now   = minute_o_r;
  assign second_now   = second_o_r;
  assign fields_valid = valid_o_r;

endmodule

FILE: rtl/calendar_clock_step.sv
// ----------------------------------------------------------------------------
// calendar_clock_step
// calendar date and time counter with step, shift and load requests
// ----------------------------------------------------------------------------
// Each input request steps the time one second up or down, shifts it by a
// signed number of minutes or hours, or loads a full date and time. Every
// request returns one result: the date and time after the request and a flag
// that says whether all fields lie in calendar range.
// A request with n unit steps (n = 1 for second steps, |delta| up to 128 for
// shifts, 0 for loads and unused codes) makes its steps after it is accepted
// and then writes its result; the counter moves one minute or hour per cycle,
// and a new request is taken only once the current one is through.
// The result sits in an output register: the next request is accepted while
// a result waits, and if the receiver stalls the block holds in its final
// cycle until the result register is free again.
// Reset sets year 0, month 1, day 1, 00:00:00 and drops out_tvalid.
// ----------------------------------------------------------------------------
module calendar_clock_step (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // operation[2:0], delta[10:3], load_year[17:11], load_month[21:18],
  // load_day[26:22], load_hour[31:27], load_minute[37:32], load_second[43:38]
  input  logic [47:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // year_now[6:0], month_now[10:7], day_now[15:11], hour_now[20:16],
  // minute_now[26:21], second_now[32:27]
  output logic [39:0] out_tdata,
  // fields_valid[0]
  output logic        out_tuser
);

  cck_pkg::dp_cmd_t cmd;
  logic [6:0]       year_now;
  logic [3:0]       month_now;
  logic [4:0]       day_now;
  logic [4:0]       hour_now;
  logic [5:0]       minute_now;
  logic [5:0]       second_now;

  cck_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .operation  (in_tdata[2:0]),
    .delta      (in_tdata[10:3]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  cck_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .load_year    (in_tdata[17:11]),
    .load_month   (in_tdata[21:18]),
    .load_day     (in_tdata[26:22]),
    .load_hour    (in_tdata[31:27]),
    .load_minute  (in_tdata[37:32]),
    .load_second  (in_tdata[43:38]),
    .year_now     (year_now),
    .month_now    (month_now),
    .day_now      (day_now),
    .hour_now     (hour_now),
    .minute_now   (minute_now),
    .second_now   (second_now),
    .fields_valid (out_tuser)
  );

  assign out_tdata = {7'd0, second_now, minute_now, hour_now, day_now, month_now, year_now};

endmodule
